// ===== rtl/clds_pkg.sv =====
package clds_pkg;

   localparam int POS_W      = 6;
   localparam int LEN_OUT_W  = 7;
   localparam int RSP_DATA_W = 16;
   localparam int RSP_PAD_W  = RSP_DATA_W - POS_W - 1 - LEN_OUT_W;

   typedef enum logic [3:0] {
      ST_LOAD,
      ST_START,
      ST_READ_I,
      ST_LATCH_I,
      ST_SCAN,
      ST_WRITE_I,
      ST_TRACE,
      ST_TRACE_WAIT,
      ST_OUT_READ,
      ST_OUT_WAIT,
      ST_OUT_HOLD
   } clds_state_type;

   typedef struct packed {
      logic load;
      logic start;
      logic read_i;
      logic latch_i;
      logic scan;
      logic write_i;
      logic trace_mark;
      logic trace_step;
      logic out_rd;
      logic out_load;
      logic out_next;
      logic finish;
   } clds_cmd_type;

   typedef struct packed {
      logic single;
      logic scan_done;
      logic last_i;
      logic trace_end;
      logic out_last;
   } clds_status_type;

endpackage

// ===== rtl/clds_ctrl.sv =====
module clds_ctrl
   import clds_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            req_tvalid,
   input  logic            req_tlast,
   input  logic            rsp_tready,
   input  clds_status_type status,
   output logic            req_tready,
   output logic            rsp_tvalid,
   output clds_cmd_type    cmd
);

   clds_state_type state_ff;
   clds_state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_LOAD;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_tready = 1'b0;
      rsp_tvalid = 1'b0;
      unique case (state_ff)
         ST_LOAD: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.load = 1'b1;
               if (req_tlast) begin
                  state_in = ST_START;
               end
            end
         end
         ST_START: begin
            cmd.start = 1'b1;
            state_in  = status.single ? ST_TRACE : ST_READ_I;
         end
         ST_READ_I: begin
            cmd.read_i = 1'b1;
            state_in   = ST_LATCH_I;
         end
         ST_LATCH_I: begin
            cmd.latch_i = 1'b1;
            state_in    = ST_SCAN;
         end
         ST_SCAN: begin
            cmd.scan = 1'b1;
            if (status.scan_done) begin
               state_in = ST_WRITE_I;
            end
         end
         ST_WRITE_I: begin
            cmd.write_i = 1'b1;
            state_in    = status.last_i ? ST_TRACE : ST_READ_I;
         end
         ST_TRACE: begin
            cmd.trace_mark = 1'b1;
            state_in       = status.trace_end ? ST_OUT_READ : ST_TRACE_WAIT;
         end
         ST_TRACE_WAIT: begin
            cmd.trace_step = 1'b1;
            state_in       = ST_TRACE;
         end
         ST_OUT_READ: begin
            cmd.out_rd = 1'b1;
            state_in   = ST_OUT_WAIT;
         end
         ST_OUT_WAIT: begin
            cmd.out_load = 1'b1;
            state_in     = ST_OUT_HOLD;
         end
         ST_OUT_HOLD: begin
            rsp_tvalid = 1'b1;
            if (rsp_tready) begin
               if (status.out_last) begin
                  cmd.finish = 1'b1;
                  state_in   = ST_LOAD;
               end else begin
                  cmd.out_next = 1'b1;
                  state_in     = ST_OUT_READ;
               end
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

endmodule

// ===== rtl/clds_dpath.sv =====
module clds_dpath
   import clds_pkg::*;
#(
   parameter int MAX_ITEMS  = 64,
   parameter int VALUE_BITS = 32
) (
   input  logic                  clock,
   input  logic                  reset,
   input  clds_cmd_type          cmd,
   input  logic [VALUE_BITS-1:0] in_value,
   output clds_status_type       status,
   output logic [POS_W-1:0]      out_position,
   output logic                  out_in_sequence,
   output logic [LEN_OUT_W-1:0]  out_chain_length,
   output logic                  out_last
);

   localparam int IDX_W = $clog2(MAX_ITEMS);
   localparam int CNT_W = $clog2(MAX_ITEMS + 1);

   logic [VALUE_BITS-1:0] val_mem [MAX_ITEMS];
   logic [CNT_W-1:0]      len_mem [MAX_ITEMS];
   logic [IDX_W-1:0]      pred_mem [MAX_ITEMS];

   logic [CNT_W-1:0]      count_ff;
   logic [IDX_W-1:0]      max_pos_ff;
   logic [VALUE_BITS-1:0] max_key_ff;
   logic [IDX_W-1:0]      i_ff;
   logic [IDX_W-1:0]      p_ff;
   logic [IDX_W-1:0]      tag_ff;
   logic [VALUE_BITS-1:0] vi_ff;
   logic [CNT_W-1:0]      acc_len_ff;
   logic [IDX_W-1:0]      acc_pred_ff;
   logic                  acc_pv_ff;
   logic [IDX_W-1:0]      best_ff;
   logic [CNT_W-1:0]      best_len_ff;
   logic [IDX_W-1:0]      o_ff;
   logic [MAX_ITEMS-1:0]  pv_ff;
   logic [MAX_ITEMS-1:0]  mark_ff;
   logic [VALUE_BITS-1:0] val_rd_ff;
   logic [CNT_W-1:0]      len_rd_ff;
   logic [IDX_W-1:0]      pred_rd_ff;

   logic [VALUE_BITS-1:0] key;
   logic [CNT_W-1:0]      n_m1;
   logic [IDX_W-1:0]      i_inc;
   logic [IDX_W-1:0]      i_dec;
   logic [IDX_W-1:0]      p_dec;
   logic [IDX_W-1:0]      s_inc;
   logic [IDX_W-1:0]      val_addr;
   logic [IDX_W-1:0]      len_addr;
   logic [CNT_W:0]        len_sum;
   logic                  better;
   logic                  store_ok;

   // order-preserving key: flip the sign bit so unsigned compare works
   assign key      = {~in_value[VALUE_BITS-1], in_value[VALUE_BITS-2:0]};
   assign n_m1     = count_ff - 1'b1;
   assign store_ok = (count_ff != CNT_W'(MAX_ITEMS));

   always_comb begin
      i_inc = (CNT_W'(i_ff) == n_m1) ? '0 : i_ff + 1'b1;
      s_inc = (CNT_W'(max_pos_ff) == n_m1) ? '0 : max_pos_ff + 1'b1;
      i_dec = (i_ff == '0) ? n_m1[IDX_W-1:0] : i_ff - 1'b1;
      p_dec = (p_ff == '0) ? n_m1[IDX_W-1:0] : p_ff - 1'b1;
   end

   assign val_addr = cmd.read_i ? i_ff : p_ff;
   assign len_addr = cmd.out_rd ? o_ff : p_ff;

   assign len_sum = {1'b0, len_rd_ff} + 1'b1;
   assign better  = (val_rd_ff > vi_ff) && (len_sum > {1'b0, acc_len_ff});

   // value store
   always_ff @(posedge clock) begin
      if (cmd.load && store_ok) begin
         val_mem[count_ff[IDX_W-1:0]] <= key;
      end
      val_rd_ff <= val_mem[val_addr];
   end

   // length store
   always_ff @(posedge clock) begin
      if (cmd.start) begin
         len_mem[max_pos_ff] <= CNT_W'(1);
      end else if (cmd.write_i) begin
         len_mem[i_ff] <= acc_len_ff;
      end
      len_rd_ff <= len_mem[len_addr];
   end

   // predecessor store
   always_ff @(posedge clock) begin
      if (cmd.write_i) begin
         pred_mem[i_ff] <= acc_pred_ff;
      end
      pred_rd_ff <= pred_mem[best_ff];
   end

   // list loading and run bookkeeping
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff   <= '0;
         max_pos_ff <= '0;
      end else if (cmd.finish) begin
         count_ff   <= '0;
         max_pos_ff <= '0;
      end else if (cmd.load && store_ok) begin
         count_ff <= count_ff + 1'b1;
         if (count_ff == '0 || key > max_key_ff) begin
            max_pos_ff <= count_ff[IDX_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load && store_ok && (count_ff == '0 || key > max_key_ff)) begin
         max_key_ff <= key;
      end
   end

   // chain scan
   always_ff @(posedge clock) begin
      if (cmd.start) begin
         i_ff <= s_inc;
      end else if (cmd.write_i) begin
         i_ff <= i_inc;
      end
      if (cmd.read_i) begin
         p_ff <= i_dec;
      end else if (cmd.latch_i || cmd.scan) begin
         p_ff   <= p_dec;
         tag_ff <= p_ff;
      end
      if (cmd.latch_i) begin
         vi_ff      <= val_rd_ff;
         acc_len_ff <= CNT_W'(1);
         acc_pv_ff  <= 1'b0;
      end else if (cmd.scan && better) begin
         acc_len_ff  <= len_sum[CNT_W-1:0];
         acc_pred_ff <= tag_ff;
         acc_pv_ff   <= 1'b1;
      end
   end

   // best end point and trace-back
   always_ff @(posedge clock) begin
      if (cmd.start) begin
         best_ff     <= max_pos_ff;
         best_len_ff <= CNT_W'(1);
      end else if (cmd.write_i && acc_len_ff > best_len_ff) begin
         best_ff     <= i_ff;
         best_len_ff <= acc_len_ff;
      end else if (cmd.trace_step) begin
         best_ff <= pred_rd_ff;
      end
   end

   // every element of the list is rewritten during the scan, the start one at start
   always_ff @(posedge clock) begin
      if (reset) begin
         pv_ff   <= '0;
         mark_ff <= '0;
      end else begin
         if (cmd.start) begin
            pv_ff[max_pos_ff]   <= 1'b0;
            mark_ff[max_pos_ff] <= 1'b0;
         end
         if (cmd.write_i) begin
            pv_ff[i_ff]   <= acc_pv_ff;
            mark_ff[i_ff] <= 1'b0;
         end
         if (cmd.trace_mark) begin
            mark_ff[best_ff] <= 1'b1;
         end
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (cmd.start) begin
         o_ff <= '0;
      end else if (cmd.out_next) begin
         o_ff <= o_ff + 1'b1;
      end
      if (cmd.out_load) begin
         out_position     <= POS_W'(o_ff);
         out_in_sequence  <= mark_ff[o_ff];
         out_chain_length <= LEN_OUT_W'(len_rd_ff);
         out_last         <= (CNT_W'(o_ff) == n_m1);
      end
   end

   always_comb begin
      status.single    = (count_ff == CNT_W'(1));
      status.scan_done = (tag_ff == max_pos_ff);
      status.last_i    = (i_inc == max_pos_ff);
      status.trace_end = !pv_ff[best_ff];
      status.out_last  = out_last;
   end

endmodule

// ===== rtl/circular_longest_decreasing_subseq.sv =====
// after the transaction carrying tlast the block runs the chain scan, then the trace-back,
// then sends one result per stored element, in order of position
// throughput: loading takes one element per cycle while no list is in work; the scan is bound
// by the single read port of the value and length stores, one compare per cycle
// reset: synchronous, clears the element count and all chain and mark flags
module circular_longest_decreasing_subseq
   import clds_pkg::*;
#(
   parameter int MAX_ITEMS  = 64,
   parameter int VALUE_BITS = 32
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [((VALUE_BITS+7)/8)*8-1:0]   req_tdata,  // value
   input  logic                              req_tlast,  // final_item
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [RSP_DATA_W-1:0]             rsp_tdata,  // position, in_sequence, chain_length
   output logic                              rsp_tlast   // last_result
);

   clds_cmd_type          cmd;
   clds_status_type       status;
   logic [POS_W-1:0]      position;
   logic                  in_sequence;
   logic [LEN_OUT_W-1:0]  chain_length;

   clds_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tlast  (req_tlast),
      .rsp_tready (rsp_tready),
      .status     (status),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .cmd        (cmd)
   );

   clds_dpath #(
      .MAX_ITEMS  (MAX_ITEMS),
      .VALUE_BITS (VALUE_BITS)
   ) u_dpath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .in_value         (req_tdata[VALUE_BITS-1:0]),
      .status           (status),
      .out_position     (position),
      .out_in_sequence  (in_sequence),
      .out_chain_length (chain_length),
      .out_last         (rsp_tlast)
   );

   assign rsp_tdata = {{RSP_PAD_W{1'b0}}, chain_length, in_sequence, position};

endmodule

// ===== bench/clds_chain_checker.sv =====
module clds_chain_checker
   import clds_pkg::*;
#(
   parameter int MAX_ELEMENTS = 64
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   input  logic                  req_tready,
   input  logic [31:0]           req_tdata,
   input  logic                  req_tlast,
   input  logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   input  logic [RSP_DATA_W-1:0] rsp_tdata,
   input  logic                  rsp_tlast,
   output int                    error_count,
   output int                    results_due
);

   typedef struct packed {
      logic [POS_W-1:0]     position;
      logic                 in_sequence;
      logic [LEN_OUT_W-1:0] chain_length;
      logic                 last_result;
   } chain_result_type;

   chain_result_type   chain_results_due[$];
   logic signed [31:0] list_values[MAX_ELEMENTS];
   int                 chain_len[MAX_ELEMENTS];
   int                 link_to[MAX_ELEMENTS];
   bit                 has_link[MAX_ELEMENTS];
   bit                 on_chain[MAX_ELEMENTS];
   int                 list_count;
   int                 top_pos;

   initial begin
      error_count = 0;
      results_due = 0;
      list_count  = 0;
      top_pos     = 0;
   end

   // walk the circle from the first maximum, then trace the first longest chain back
   function automatic void predict_chain_marks();
      int               n;
      int               s;
      int               i;
      int               p;
      int               best;
      chain_result_type r;
      n = list_count;
      s = top_pos;
      for (i = 0; i < MAX_ELEMENTS; i++) begin
         has_link[i] = 0;
         on_chain[i] = 0;
      end
      chain_len[s] = 1;
      for (int k = 1; k < n; k++) begin
         i = (s + k) % n;
         chain_len[i] = 1;
         for (int j = k; j > 0; j--) begin
            p = (s + j - 1) % n;
            if (list_values[p] > list_values[i] && chain_len[p] + 1 > chain_len[i]) begin
               chain_len[i] = chain_len[p] + 1;
               link_to[i]   = p;
               has_link[i]  = 1;
            end
         end
      end
      best = s;
      for (int k = 1; k < n; k++) begin
         i = (s + k) % n;
         if (chain_len[i] > chain_len[best]) best = i;
      end
      for (int guard = 0; guard < n; guard++) begin
         on_chain[best] = 1;
         if (!has_link[best]) break;
         best = link_to[best] % n;
      end
      for (i = 0; i < n; i++) begin
         r.position     = POS_W'(i);
         r.in_sequence  = on_chain[i];
         r.chain_length = LEN_OUT_W'(chain_len[i]);
         r.last_result  = (i == n - 1);
         chain_results_due.push_back(r);
      end
   endfunction

   function automatic void compare_field(string name, int due, int seen);
      if (due != seen) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, due, seen);
         error_count++;
      end
   endfunction

   always @(posedge clock) begin
      chain_result_type due;
      if (reset) begin
         list_count  = 0;
         top_pos     = 0;
         chain_results_due.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (chain_results_due.size() == 0) begin
               $display("%0t: unexpected result, expected none, actual position %0d length %0d",
                        $time, rsp_tdata[POS_W-1:0], rsp_tdata[POS_W+1 +: LEN_OUT_W]);
               error_count++;
            end else begin
               due = chain_results_due.pop_front();
               compare_field("position", due.position, rsp_tdata[POS_W-1:0]);
               compare_field("in_sequence", due.in_sequence, rsp_tdata[POS_W]);
               compare_field("chain_length", due.chain_length, rsp_tdata[POS_W+1 +: LEN_OUT_W]);
               compare_field("last_result", due.last_result, rsp_tlast);
               compare_field("padding", 0, rsp_tdata[RSP_DATA_W-1 -: RSP_PAD_W]);
            end
         end
         if (req_tvalid && req_tready) begin
            // elements past a full store are dropped
            if (list_count < MAX_ELEMENTS) begin
               list_values[list_count] = req_tdata;
               if (list_count == 0 || list_values[list_count] > list_values[top_pos])
                  top_pos = list_count;
               list_count++;
            end
            if (req_tlast) begin
               predict_chain_marks();
               list_count = 0;
               top_pos    = 0;
            end
         end
      end
      results_due = chain_results_due.size();
   end

endmodule

// ===== bench/tb_circular_longest_decreasing_subseq.sv =====
module tb_circular_longest_decreasing_subseq
   import clds_pkg::*;
();

   localparam int CLOCK_PERIOD    = 20;
   localparam int LIST_ITEMS      = 64;
   localparam int RANDOM_ELEMENTS = 30;
   localparam int CYCLE_LIMIT     = 1_000_000;

   typedef enum int {
      VALUES_WIDE,
      VALUES_NARROW,
      VALUES_FALLING
   } value_style_type;

   logic                  clock;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [31:0]           req_tdata;
   logic                  req_tlast;
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  rsp_tlast;
   int                    error_count;
   int                    results_due;
   bit                    no_gaps;

   circular_longest_decreasing_subseq i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   clds_chain_checker i_checker (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tlast   (req_tlast),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast),
      .error_count (error_count),
      .results_due (results_due)
   );

   initial clock = 0;
   always #(CLOCK_PERIOD / 2) clock = ~clock;

   initial begin
      #(CLOCK_PERIOD * CYCLE_LIMIT);
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 50) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 10);
      return $urandom_range(20, 40);
   endfunction

   function automatic logic signed [31:0] pick_value(value_style_type style, int k);
      int r;
      r = $urandom_range(0, 99);
      if (r < 8) begin
         case ($urandom_range(0, 3))
            0:       return 32'sh7fffffff;
            1:       return 32'sh80000000;
            2:       return 0;
            default: return -1;
         endcase
      end
      case (style)
         VALUES_WIDE:   return $urandom;
         VALUES_NARROW: return $signed($urandom_range(0, 8)) - 4;
         default:       return 1000 - 37 * k + $signed($urandom_range(0, 60));
      endcase
   endfunction

   task automatic send_element(input logic signed [31:0] v, input bit is_last);
      int gap;
      gap = no_gaps ? 0 : pick_gap();
      if (gap > 0) begin
         req_tvalid <= 0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1;
      req_tdata  <= v;
      req_tlast  <= is_last;
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
   endtask

   task automatic send_list(input int n, input value_style_type style);
      for (int k = 0; k < n; k++) send_element(pick_value(style, k), k == n - 1);
   endtask

   task automatic drain_results();
      req_tvalid <= 0;
      while (results_due != 0) @(negedge clock);
   endtask

   // receiver: bursts of readiness, short stalls and the odd long one
   initial begin
      int hold;
      int r;
      bit ready_now;
      rsp_tready = 0;
      hold       = 0;
      ready_now  = 0;
      forever begin
         @(negedge clock);
         if (hold == 0) begin
            r = $urandom_range(0, 99);
            if (r < 45) begin
               ready_now = 1;
               hold      = $urandom_range(1, 40);
            end else if (r < 93) begin
               ready_now = 0;
               hold      = $urandom_range(1, 3);
            end else begin
               ready_now = 0;
               hold      = $urandom_range(15, 40);
            end
         end
         hold--;
         rsp_tready <= ready_now;
      end
   end

   initial begin
      int sent;
      int list_no;
      int n;
      int r;
      reset      = 1;
      req_tvalid = 0;
      req_tdata  = 0;
      req_tlast  = 0;
      no_gaps    = 0;
      repeat (2) @(negedge clock);
      reset <= 0;

      // extremes of the value range
      send_element(32'sh7fffffff, 0);
      send_element(32'sh80000000, 1);
      // single element
      send_element(0, 1);
      // equal maxima
      send_element(5, 0);
      send_element(5, 0);
      send_element(3, 0);
      send_element(5, 0);
      send_element(1, 1);
      // chain wraps round the end of the list
      send_element(3, 0);
      send_element(9, 0);
      send_element(7, 0);
      send_element(5, 1);
      // tie in length, nearest predecessor wins
      send_element(9, 0);
      send_element(5, 0);
      send_element(6, 0);
      send_element(1, 1);
      drain_results();

      // full store with dropped elements, last mark on a dropped one
      send_list(LIST_ITEMS + 3, VALUES_NARROW);
      send_list(LIST_ITEMS, VALUES_FALLING);
      sent    = 2 * LIST_ITEMS + 3;
      list_no = 0;
      while (sent < 2 * LIST_ITEMS + 3 + RANDOM_ELEMENTS) begin
         r = $urandom_range(0, 99);
         if (r < 75) n = $urandom_range(1, 12);
         else if (r < 92) n = $urandom_range(13, 30);
         else n = LIST_ITEMS;
         no_gaps = (list_no % 4 == 3);
         send_list(n, value_style_type'($urandom_range(0, 2)));
         sent += n;
         list_no++;
         if (list_no % 5 == 4 && sent < 2 * LIST_ITEMS + 3 + RANDOM_ELEMENTS) drain_results();
      end

      drain_results();
      repeat (200) @(negedge clock);
      if (error_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
